[hw/rtl/encoder_move_sequencer_top_assert.svh]
// Assertion macros shared by the RTL files.
`ifndef ENCODER_MOVE_SEQUENCER_TOP_ASSERT_SVH
`define ENCODER_MOVE_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define EMS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ems assertion failed");

// Next-cycle implication, checked outside reset.
`define EMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ems assertion failed");

`endif

[hw/rtl/ems_pkg.sv]
package ems_pkg;

  localparam int CFG_INDEX_WIDTH  = 1;
  localparam int CFG_DATA_WIDTH   = 16;
  localparam int CELL_WIDTH       = 16;
  localparam int TURN_WIDTH       = 15;
  localparam int COUNT_WIDTH      = 16;
  localparam int CMD_WIDTH        = 3;
  localparam int HEAD_WIDTH       = 2;
  localparam int POS_OUT_WIDTH    = 16;
  localparam int TOTAL_OUT_WIDTH  = 32;
  localparam int COORD_EXT_WIDTH  = 32;
  localparam int TOTAL_EXT_WIDTH  = 64;
  localparam int DEF_COORD_WIDTH  = 16;
  localparam int DEF_TOTAL_WIDTH  = 32;

  localparam logic [CELL_WIDTH-1:0] CELL_RESET = 16'd360;
  localparam logic [TURN_WIDTH-1:0] TURN_RESET = 15'd90;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CELL_PULSES   = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TURN90_PULSES = 1'd1;

  typedef logic [CMD_WIDTH-1:0] cmd_t;
  typedef logic [1:0]           move_t;
  typedef logic [HEAD_WIDTH-1:0] head_t;

  localparam cmd_t CMD_NONE  = 3'd0;
  localparam cmd_t CMD_FWD   = 3'd1;
  localparam cmd_t CMD_LEFT  = 3'd2;
  localparam cmd_t CMD_RIGHT = 3'd3;
  localparam cmd_t CMD_ABOUT = 3'd4;

  localparam move_t MV_FWD   = 2'd0;
  localparam move_t MV_LEFT  = 2'd1;
  localparam move_t MV_RIGHT = 2'd2;
  localparam move_t MV_ABOUT = 2'd3;

  localparam head_t HEAD_NORTH = 2'd0;
  localparam head_t HEAD_EAST  = 2'd1;
  localparam head_t HEAD_SOUTH = 2'd2;
  localparam head_t HEAD_WEST  = 2'd3;

  typedef struct packed {
    logic  done;
    logic  rejected;
    logic  moving;
    move_t done_move;
    logic  left_in1;
    logic  left_in2;
    logic  right_in1;
    logic  right_in2;
  } ems_status_t;

endpackage

[hw/rtl/ems_move.sv]
`include "encoder_move_sequencer_top_assert.svh"

module ems_move import ems_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  cmd_t                  command,
  input  logic                  left_pulse,
  input  logic                  right_pulse,
  input  logic [CELL_WIDTH-1:0] cell_pulses,
  input  logic [TURN_WIDTH-1:0] turn90_pulses,
  output ems_status_t           status
);

  logic                   moving;
  move_t                  active_move;
  logic [COUNT_WIDTH-1:0] target_count;
  logic [COUNT_WIDTH-1:0] left_count;
  logic [COUNT_WIDTH-1:0] right_count;

  logic                   moving_next;
  move_t                  active_move_next;
  logic [COUNT_WIDTH-1:0] target_count_next;
  logic [COUNT_WIDTH-1:0] left_count_next;
  logic [COUNT_WIDTH-1:0] right_count_next;

  logic [COUNT_WIDTH-1:0] left_inc;
  logic [COUNT_WIDTH-1:0] right_inc;
  logic [COUNT_WIDTH-1:0] target_sel;
  logic                   done;
  logic                   move_cmd;
  logic                   start;
  move_t                  move_sel;

  always_comb begin
    left_inc  = (left_pulse && !(&left_count)) ? left_count + COUNT_WIDTH'(1) : left_count;
    right_inc = (right_pulse && !(&right_count)) ? right_count + COUNT_WIDTH'(1)
                                                 : right_count;
    done      = moving && (left_inc >= target_count) && (right_inc >= target_count);

    move_cmd = (command == CMD_FWD) || (command == CMD_LEFT) ||
               (command == CMD_RIGHT) || (command == CMD_ABOUT);
    start    = move_cmd && !moving;

    case (command)
      CMD_FWD:   move_sel = MV_FWD;
      CMD_LEFT:  move_sel = MV_LEFT;
      CMD_RIGHT: move_sel = MV_RIGHT;
      default:   move_sel = MV_ABOUT;
    endcase

    case (move_sel)
      MV_FWD:   target_sel = cell_pulses;
      MV_ABOUT: target_sel = {turn90_pulses, 1'b0};
      default:  target_sel = {1'b0, turn90_pulses};
    endcase

    moving_next       = start || (moving && !done);
    active_move_next  = start ? move_sel : active_move;
    target_count_next = start ? target_sel : target_count;
    left_count_next   = start ? '0 : (moving ? left_inc : left_count);
    right_count_next  = start ? '0 : (moving ? right_inc : right_count);

    status.done      = done;
    status.rejected  = move_cmd && moving;
    status.moving    = moving_next;
    status.done_move = active_move;
    status.left_in1  = 1'b0;
    status.left_in2  = 1'b0;
    status.right_in1 = 1'b0;
    status.right_in2 = 1'b0;
    if (moving_next) begin
      case (active_move_next)
        MV_FWD: begin
          status.left_in1  = 1'b1;
          status.right_in1 = 1'b1;
        end
        MV_LEFT: begin
          status.left_in2  = 1'b1;
          status.right_in1 = 1'b1;
        end
        default: begin
          status.left_in1  = 1'b1;
          status.right_in2 = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      moving       <= 1'b0;
      active_move  <= MV_FWD;
      target_count <= '0;
      left_count   <= '0;
      right_count  <= '0;
    end else if (step) begin
      moving       <= moving_next;
      active_move  <= active_move_next;
      target_count <= target_count_next;
      left_count   <= left_count_next;
      right_count  <= right_count_next;
    end
  end

  `EMS_ASSERT_NOW(a_done_needs_move, clk, rst, step && done, moving)
  `EMS_ASSERT_NOW(a_reject_needs_move, clk, rst, step && status.rejected, moving && !start)
  `EMS_ASSERT_NEXT(a_start_clears_counts, clk, rst, step && start,
                   moving && (left_count == '0) && (right_count == '0))

endmodule

[hw/rtl/encoder_move_sequencer_top.sv]
// Two-wheel move sequencer.
// Input channel (in_valid / in_stall): command, left_pulse, right_pulse. One
// transfer per clock carries one command code and at most one encoder pulse
// for each wheel; code 0 carries pulses only.
// Output channel (out_valid / out_stall): exactly one result per input
// transfer, in order: H-bridge levels, busy, done, rejected, heading, cell
// position and the pulse totals saved at the last forward completion.
// Each result passes through the input register, then through the
// sequencing logic into the result register.
// Throughput is one item per cycle while out_stall is low, set by the
// registered update of the move counters and position registers.
// When the receiver stalls, the result register holds; one more item waits in
// the input register, then in_stall rises in the same cycle.
// Configuration (cfg_we, cfg_index, cfg_data) writes cell_pulses (index 0) or
// turn90_pulses (index 1); write only while no item is in flight.
// Synchronous reset ends any move in progress, sets heading north at cell (0,0),
// clears all totals and loads cell_pulses 360 and turn90_pulses 90.
`include "encoder_move_sequencer_top_assert.svh"

module encoder_move_sequencer_top import ems_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int TOTAL_WIDTH = DEF_TOTAL_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  cmd_t                              command,
  input  logic                              left_pulse,
  input  logic                              right_pulse,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              left_in1,
  output logic                              left_in2,
  output logic                              right_in1,
  output logic                              right_in2,
  output logic                              busy_res,
  output logic                              move_done,
  output logic                              rejected,
  output head_t                             heading,
  output logic signed [POS_OUT_WIDTH-1:0]   pos_x,
  output logic signed [POS_OUT_WIDTH-1:0]   pos_y,
  output logic        [TOTAL_OUT_WIDTH-1:0] saved_left_total,
  output logic        [TOTAL_OUT_WIDTH-1:0] saved_right_total,
  input  logic                              cfg_we,
  input  logic        [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic        [CFG_DATA_WIDTH-1:0]  cfg_data
);

  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_ONE = COORD_WIDTH'(1);

  logic [CELL_WIDTH-1:0] cell_pulses;
  logic [TURN_WIDTH-1:0] turn90_pulses;

  logic in_q_valid;
  cmd_t cmd_q;
  logic left_pulse_q;
  logic right_pulse_q;
  logic advance;
  logic step;

  ems_status_t status;

  head_t                         heading_reg;
  logic signed [COORD_WIDTH-1:0] x_reg;
  logic signed [COORD_WIDTH-1:0] y_reg;
  logic [TOTAL_WIDTH-1:0]        left_total;
  logic [TOTAL_WIDTH-1:0]        right_total;
  logic [TOTAL_WIDTH-1:0]        saved_left;
  logic [TOTAL_WIDTH-1:0]        saved_right;

  head_t                         heading_next;
  logic signed [COORD_WIDTH-1:0] x_next;
  logic signed [COORD_WIDTH-1:0] y_next;
  logic [TOTAL_WIDTH-1:0]        left_total_next;
  logic [TOTAL_WIDTH-1:0]        right_total_next;
  logic [TOTAL_WIDTH-1:0]        saved_left_next;
  logic [TOTAL_WIDTH-1:0]        saved_right_next;

  logic signed [COORD_EXT_WIDTH-1:0] x_ext;
  logic signed [COORD_EXT_WIDTH-1:0] y_ext;
  logic [TOTAL_EXT_WIDTH-1:0]        saved_left_ext;
  logic [TOTAL_EXT_WIDTH-1:0]        saved_right_ext;

  assign advance  = !out_valid || !out_stall;
  assign step     = in_q_valid && advance;
  assign in_stall = in_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_pulses   <= CELL_RESET;
      turn90_pulses <= TURN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CELL_PULSES:   cell_pulses   <= cfg_data[CELL_WIDTH-1:0];
        REG_TURN90_PULSES: turn90_pulses <= cfg_data[TURN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_q_valid <= 1'b1;
    end else if (step) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_q         <= command;
      left_pulse_q  <= left_pulse;
      right_pulse_q <= right_pulse;
    end
  end

  ems_move u_move (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .command       (cmd_q),
    .left_pulse    (left_pulse_q),
    .right_pulse   (right_pulse_q),
    .cell_pulses   (cell_pulses),
    .turn90_pulses (turn90_pulses),
    .status        (status)
  );

  always_comb begin
    left_total_next  = left_total + TOTAL_WIDTH'(left_pulse_q);
    right_total_next = right_total + TOTAL_WIDTH'(right_pulse_q);
    heading_next     = heading_reg;
    x_next           = x_reg;
    y_next           = y_reg;
    saved_left_next  = saved_left;
    saved_right_next = saved_right;
    if (status.done) begin
      case (status.done_move)
        MV_FWD: begin
          case (heading_reg)
            HEAD_NORTH: y_next = (y_reg == COORD_MAX) ? y_reg : y_reg + COORD_ONE;
            HEAD_EAST:  x_next = (x_reg == COORD_MAX) ? x_reg : x_reg + COORD_ONE;
            HEAD_SOUTH: y_next = (y_reg == COORD_MIN) ? y_reg : y_reg - COORD_ONE;
            default:    x_next = (x_reg == COORD_MIN) ? x_reg : x_reg - COORD_ONE;
          endcase
          saved_left_next  = left_total_next;
          saved_right_next = right_total_next;
        end
        MV_LEFT:  heading_next = heading_reg + 2'd3;
        MV_RIGHT: heading_next = heading_reg + 2'd1;
        default:  heading_next = heading_reg + 2'd2;
      endcase
    end
    x_ext           = COORD_EXT_WIDTH'(x_next);
    y_ext           = COORD_EXT_WIDTH'(y_next);
    saved_left_ext  = TOTAL_EXT_WIDTH'(saved_left_next);
    saved_right_ext = TOTAL_EXT_WIDTH'(saved_right_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heading_reg <= HEAD_NORTH;
      x_reg       <= '0;
      y_reg       <= '0;
      left_total  <= '0;
      right_total <= '0;
      saved_left  <= '0;
      saved_right <= '0;
    end else if (step) begin
      heading_reg <= heading_next;
      x_reg       <= x_next;
      y_reg       <= y_next;
      left_total  <= left_total_next;
      right_total <= right_total_next;
      saved_left  <= saved_left_next;
      saved_right <= saved_right_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      left_in1          <= status.left_in1;
      left_in2          <= status.left_in2;
      right_in1         <= status.right_in1;
      right_in2         <= status.right_in2;
      busy_res          <= status.moving;
      move_done         <= status.done;
      rejected          <= status.rejected;
      heading           <= heading_next;
      pos_x             <= x_ext[POS_OUT_WIDTH-1:0];
      pos_y             <= y_ext[POS_OUT_WIDTH-1:0];
      saved_left_total  <= saved_left_ext[TOTAL_OUT_WIDTH-1:0];
      saved_right_total <= saved_right_ext[TOTAL_OUT_WIDTH-1:0];
    end
  end

  `EMS_ASSERT_NOW(a_done_stops_motors, clk, rst, out_valid && move_done, !busy_res)
  `EMS_ASSERT_NOW(a_idle_pins_low, clk, rst, out_valid && !busy_res,
                  !left_in1 && !left_in2 && !right_in1 && !right_in2)
  `EMS_ASSERT_NEXT(a_step_fills_output, clk, rst, step, out_valid)

endmodule
